// File: hdl/rtdd_pkg.sv
// rtdd_pkg: shared types and constants of the RGB 2-D delta encoder.
// Register indexes, sample widths and the stage control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtdd_pkg;

	localparam int SAMPLE_W = 8;
	localparam int PIXEL_W  = 3 * SAMPLE_W;
	localparam int CFG_DW   = 13;
	localparam int CFG_IW   = 1;

	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [PIXEL_W-1:0]  pixel_t;

	// frame position flags of a pixel in flight
	typedef struct packed {
		logic first_col;
		logic first_row;
		logic eof;
	} rtdd_ctl_t;

endpackage

`default_nettype wire

// File: hdl/rtdd_ram.sv
// rtdd_ram: generic single-write, single-read RAM with registered read data.
// Read-first on a shared address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtdd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/rtdd_lane.sv
// rtdd_lane: one colour channel of the 2-D delta, with its own left and
// above-left history. Depends on rtdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtdd_lane
	import rtdd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      adv,
	input  wire rtdd_ctl_t ctl,
	input  wire sample_t   cur,
	input  wire sample_t   above_raw,
	output sample_t        delta
);

	sample_t left_q;
	sample_t above_left_q;
	sample_t above;
	sample_t left;
	sample_t above_left;

	always_comb begin
		above      = ctl.first_row ? '0 : above_raw;
		left       = ctl.first_col ? '0 : left_q;
		above_left = ctl.first_col ? '0 : above_left_q;
		delta      = cur - above - left + above_left;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q       <= cur;
			above_left_q <= above;
		end
	end

endmodule

`default_nettype wire

// File: hdl/rtdd_merge.sv
// rtdd_merge: combines the three lane deltas into the green-difference
// result and holds it in the output register. Depends on rtdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtdd_merge
	import rtdd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_s1,
	input  wire rtdd_ctl_t ctl_s1,
	input  wire sample_t   d_red,
	input  wire sample_t   d_green,
	input  wire sample_t   d_blue,
	input  wire logic      out_stall,
	output logic           adv,
	output logic           out_valid,
	output sample_t        green_residual,
	output sample_t        red_minus_green,
	output sample_t        blue_minus_green,
	output logic           end_of_frame
);

	assign adv = valid_s1 && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			green_residual   <= d_green;
			red_minus_green  <= d_red - d_green;
			blue_minus_green <= d_blue - d_green;
			end_of_frame     <= ctl_s1.eof;
		end
	end

endmodule

`default_nettype wire

// File: hdl/rgb_two_d_delta_encoder_core.sv
// rgb_two_d_delta_encoder_core: top level of the RGB 2-D delta encoder.
// Uses rtdd_pkg, rtdd_ram, rtdd_lane and rtdd_merge.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   pixel in | in_valid / in_stall      | red, green, blue
//   result   | out_valid / out_stall    | green_residual, red_minus_green,
//            |                          | blue_minus_green, end_of_frame
//   config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One pixel per clock unless stalled; registered in stage and output regs.
// The line store is read and written at accept time, one port each.
// Reset clears counters and valids; the line store is not cleared.
// in_stall rises only when the stage and the output register are both full
// and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module rgb_two_d_delta_encoder_core
	import rtdd_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sample_t           red,
	input  wire sample_t           green,
	input  wire sample_t           blue,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output sample_t                green_residual,
	output sample_t                red_minus_green,
	output sample_t                blue_minus_green,
	output logic                   end_of_frame,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW  = 18;
	localparam logic [CW-1:0] WLIM_RST = CW'(((MAX_WIDTH < 4096) ? MAX_WIDTH : 4096) - 1);
	localparam logic [RW-1:0] HLIM_RST = RW'(((MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096) - 1);

	logic [CW-1:0] width_lim_q;
	logic [RW-1:0] height_lim_q;
	logic [CW-1:0] width_lim_d;
	logic [RW-1:0] height_lim_d;
	logic [XW-1:0] cfg_x;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col;
	logic          last_row;
	logic          accept;
	logic          adv;

	logic          valid_s1;
	rtdd_ctl_t     ctl_s1;
	pixel_t        cur_s1;
	pixel_t        cur;
	pixel_t        above_raw;
	sample_t       d_lane [3];

	// size registers hold the clamped limit minus one
	assign cfg_ready = 1'b1;
	assign cfg_x     = XW'(cfg_data);

	always_comb begin
		if (cfg_x == '0) begin
			width_lim_d  = '0;
			height_lim_d = '0;
		end else begin
			width_lim_d  = (cfg_x > XW'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(cfg_x - 1'b1);
			height_lim_d = (cfg_x > XW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) : RW'(cfg_x - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_lim_q  <= WLIM_RST;
			height_lim_q <= HLIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_lim_q  <= width_lim_d;
				REG_IMAGE_HEIGHT: height_lim_q <= height_lim_d;
				default: ;
			endcase
		end
	end

	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign cur      = {red, green, blue};
	assign last_col = (col_q >= width_lim_q);
	assign last_row = (row_q >= height_lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1           <= cur;
			ctl_s1.first_col <= (col_q == '0);
			ctl_s1.first_row <= (row_q == '0);
			ctl_s1.eof       <= last_col && last_row;
		end
	end

	rtdd_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cur),
		.re    (accept),
		.raddr (col_q),
		.rdata (above_raw)
	);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rtdd_lane u_lane (
			.clk       (clk),
			.adv       (adv),
			.ctl       (ctl_s1),
			.cur       (cur_s1[PIXEL_W-1-g*SAMPLE_W -: SAMPLE_W]),
			.above_raw (above_raw[PIXEL_W-1-g*SAMPLE_W -: SAMPLE_W]),
			.delta     (d_lane[g])
		);
	end

	rtdd_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s1         (valid_s1),
		.ctl_s1           (ctl_s1),
		.d_red            (d_lane[0]),
		.d_green          (d_lane[1]),
		.d_blue           (d_lane[2]),
		.out_stall        (out_stall),
		.adv              (adv),
		.out_valid        (out_valid),
		.green_residual   (green_residual),
		.red_minus_green  (red_minus_green),
		.blue_minus_green (blue_minus_green),
		.end_of_frame     (end_of_frame)
	);

	a_stall_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	a_first_col_tag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (col_q == '0) |=> ctl_s1.first_col)
		else $error("column zero request lost its first-column flag");

	a_eof_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col && last_row |=> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap after end of frame");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("result dropped on the way to the output register");

endmodule

`default_nettype wire
